// ===== rtl/core/rcsb_pkg.sv =====
`default_nettype none

package rcsb_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int MAX_KNOTS  = 6;
    localparam int X_W        = 24;
    localparam int U_W        = X_W;
    localparam int SQ_W       = 2 * U_W;
    localparam int POW_W      = 3 * U_W - 2 * FRAC_BITS;
    localparam int LAM_W      = FRAC_BITS + 1;
    localparam int VAL_W      = 64;
    localparam int COL_W      = 3;
    localparam int CNT_W      = 3;
    localparam int IDX_W      = 3;
    localparam int NLAM       = MAX_KNOTS - 2;
    localparam int LAM_IDX_W  = $clog2(NLAM);
    localparam int STEP_W     = $clog2(FRAC_BITS);
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = QPTR_W + 1;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 72;

    localparam logic [IDX_W-1:0] CFG_KNOT_COUNT = 3'd0;
    localparam logic [IDX_W-1:0] CFG_KNOT_BASE  = 3'd1;

    localparam logic [COL_W-1:0] COL_CONST  = 3'd0;
    localparam logic [COL_W-1:0] COL_LINEAR = 3'd1;
    localparam logic [COL_W-1:0] COL_SPLINE = 3'd2;

    typedef logic signed [X_W-1:0]   knot_t;
    typedef logic        [U_W-1:0]   mag_t;
    typedef logic        [SQ_W-1:0]  sq_t;
    typedef logic        [POW_W-1:0] pow_t;
    typedef logic        [LAM_W-1:0] lam_t;
    typedef logic signed [VAL_W-1:0] val_t;

    localparam lam_t LAM_ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam val_t VAL_ONE = {{(VAL_W-LAM_W){1'b0}}, LAM_ONE};

    typedef enum logic [1:0] {
        LAM_IDLE,
        LAM_SETUP,
        LAM_DIV
    } lam_state_t;

    typedef struct packed {
        logic                         busy;
        logic                         degen;
        logic [CNT_W-1:0]             n;
        knot_t                        first;
        knot_t                        last;
        knot_t [MAX_KNOTS-1:0]        knot;
        lam_t  [NLAM-1:0]             lam;
    } cfg_view_t;

    typedef struct packed {
        knot_t x;
        logic  deriv;
        pow_t  pf;
        pow_t  pl;
    } smp_t;

    // positive part of a - b
    function automatic mag_t pos_diff(knot_t a, knot_t b);
        logic signed [X_W:0] d;
        d = {a[X_W-1], a} - {b[X_W-1], b};
        pos_diff = (!d[X_W] && (d != '0)) ? d[U_W-1:0] : '0;
    endfunction

    // second half of the truncated power: cube or three times square
    function automatic pow_t pow_fin(sq_t sq, mag_t u, logic deriv);
        logic [SQ_W+1:0]                   t3;
        logic [SQ_W-FRAC_BITS+U_W-1:0]     m;
        t3 = {2'b00, sq} + {1'b0, sq, 1'b0};
        m  = sq[SQ_W-1:FRAC_BITS] * u;
        if (deriv)
            pow_fin = POW_W'(t3[SQ_W+1:FRAC_BITS]);
        else
            pow_fin = m[SQ_W-FRAC_BITS+U_W-1:FRAC_BITS];
    endfunction

    function automatic pow_t weight(pow_t p, lam_t l);
        logic [POW_W+LAM_W-1:0] pr;
        pr = p * l;
        weight = pr[POW_W+FRAC_BITS-1:FRAC_BITS];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rcsb_cfg.sv =====
`default_nettype none

module rcsb_cfg (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [rcsb_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [rcsb_pkg::X_W-1:0]    cfg_data,
    output rcsb_pkg::cfg_view_t              cfg
);

    logic [rcsb_pkg::CNT_W-1:0]                   cnt_reg, cnt_next;
    rcsb_pkg::knot_t [rcsb_pkg::MAX_KNOTS-1:0]    knot_reg, knot_next;
    rcsb_pkg::lam_t  [rcsb_pkg::NLAM-1:0]         lam_reg, lam_next;
    rcsb_pkg::lam_state_t                         state_reg, state_next;
    logic [rcsb_pkg::LAM_IDX_W-1:0]               idx_reg, idx_next;
    logic [rcsb_pkg::STEP_W-1:0]                  step_reg, step_next;
    rcsb_pkg::mag_t                               rem_reg, rem_next;
    logic [rcsb_pkg::FRAC_BITS-1:0]               quo_reg, quo_next;

    logic [rcsb_pkg::CNT_W-1:0]  n_eff;
    logic [rcsb_pkg::IDX_W-1:0]  last_idx;
    logic [rcsb_pkg::IDX_W-1:0]  kidx;
    rcsb_pkg::knot_t             first_k, last_k, kj;
    logic signed [rcsb_pkg::X_W:0] num, den, anum, aden;
    rcsb_pkg::mag_t              an, ad;
    logic                        neg, degen;
    logic [rcsb_pkg::U_W:0]      rem2;
    logic                        ge;
    logic                        wr;
    rcsb_pkg::lam_t              wval;

    always_comb
    begin
        if (cnt_reg < rcsb_pkg::CNT_W'(2))
            n_eff = rcsb_pkg::CNT_W'(2);
        else if (cnt_reg > rcsb_pkg::CNT_W'(rcsb_pkg::MAX_KNOTS))
            n_eff = rcsb_pkg::CNT_W'(rcsb_pkg::MAX_KNOTS);
        else
            n_eff = cnt_reg;
    end

    assign last_idx = n_eff - rcsb_pkg::IDX_W'(1);
    assign first_k  = knot_reg[0];
    assign last_k   = knot_reg[last_idx];
    assign kidx     = rcsb_pkg::IDX_W'(idx_reg) + rcsb_pkg::IDX_W'(1);
    assign kj       = knot_reg[kidx];

    assign num   = {last_k[rcsb_pkg::X_W-1], last_k} - {kj[rcsb_pkg::X_W-1], kj};
    assign den   = {last_k[rcsb_pkg::X_W-1], last_k} - {first_k[rcsb_pkg::X_W-1], first_k};
    assign anum  = num[rcsb_pkg::X_W] ? -num : num;
    assign aden  = den[rcsb_pkg::X_W] ? -den : den;
    assign an    = anum[rcsb_pkg::U_W-1:0];
    assign ad    = aden[rcsb_pkg::U_W-1:0];
    assign neg   = num[rcsb_pkg::X_W] != den[rcsb_pkg::X_W];
    assign degen = (den == '0);
    assign rem2  = {rem_reg, 1'b0};
    assign ge    = rem2 >= {1'b0, ad};

    always_comb
    begin
        cnt_next   = cnt_reg;
        knot_next  = knot_reg;
        lam_next   = lam_reg;
        state_next = state_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        wr         = 1'b0;
        wval       = '0;

        case (state_reg)
            rcsb_pkg::LAM_IDLE:
            begin
            end
            rcsb_pkg::LAM_SETUP:
            begin
                if (degen || ((an != '0) && neg))
                begin
                    wr   = 1'b1;
                    wval = '0;
                end
                else if (an >= ad)
                begin
                    wr   = 1'b1;
                    wval = rcsb_pkg::LAM_ONE;
                end
                else
                begin
                    rem_next   = an;
                    quo_next   = '0;
                    step_next  = '0;
                    state_next = rcsb_pkg::LAM_DIV;
                end
            end
            rcsb_pkg::LAM_DIV:
            begin
                rem_next  = ge ? rem2[rcsb_pkg::U_W-1:0] - ad : rem2[rcsb_pkg::U_W-1:0];
                quo_next  = {quo_reg[rcsb_pkg::FRAC_BITS-2:0], ge};
                step_next = step_reg + rcsb_pkg::STEP_W'(1);
                if (step_reg == rcsb_pkg::STEP_W'(rcsb_pkg::FRAC_BITS - 1))
                begin
                    wr   = 1'b1;
                    wval = {1'b0, quo_next};
                end
            end
            default:
            begin
                state_next = rcsb_pkg::LAM_IDLE;
            end
        endcase

        if (wr)
        begin
            lam_next[idx_reg] = wval;
            if (idx_reg == rcsb_pkg::LAM_IDX_W'(rcsb_pkg::NLAM - 1))
                state_next = rcsb_pkg::LAM_IDLE;
            else
            begin
                idx_next   = idx_reg + rcsb_pkg::LAM_IDX_W'(1);
                state_next = rcsb_pkg::LAM_SETUP;
            end
        end

        if (cfg_we)
        begin
            if (cfg_index == rcsb_pkg::CFG_KNOT_COUNT)
                cnt_next = cfg_data[rcsb_pkg::CNT_W-1:0];
            for (int k = 0; k < rcsb_pkg::MAX_KNOTS; k++)
            begin
                if (cfg_index == rcsb_pkg::CFG_KNOT_BASE + rcsb_pkg::IDX_W'(k))
                    knot_next[k] = cfg_data;
            end
            // any write restarts the lambda sweep
            state_next = rcsb_pkg::LAM_SETUP;
            idx_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= rcsb_pkg::CNT_W'(2);
            knot_reg  <= '0;
            lam_reg   <= '0;
            state_reg <= rcsb_pkg::LAM_IDLE;
            idx_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            knot_reg  <= knot_next;
            lam_reg   <= lam_next;
            state_reg <= state_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign cfg.busy  = (state_reg != rcsb_pkg::LAM_IDLE);
    assign cfg.degen = degen;
    assign cfg.n     = n_eff;
    assign cfg.first = first_k;
    assign cfg.last  = last_k;
    assign cfg.knot  = knot_reg;
    assign cfg.lam   = lam_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rcsb_front.sv =====
`default_nettype none

module rcsb_front (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [rcsb_pkg::X_W-1:0]  s_tdata,
    input  wire logic                      s_tuser,
    input  wire logic                      cfg_we,
    input  wire rcsb_pkg::cfg_view_t       cfg,
    input  wire logic                      q_full,
    output logic                           push,
    output rcsb_pkg::smp_t                 push_data
);

    logic v0_reg, v0_next, v1_reg, v1_next, v2_reg, v2_next;
    logic adv, acc;

    rcsb_pkg::knot_t x0_reg, x1_reg, x2_reg;
    logic            d0_reg, d1_reg, d2_reg;
    rcsb_pkg::mag_t  uf0_reg, ul0_reg, uf1_reg, ul1_reg;
    rcsb_pkg::sq_t   sqf1_reg, sql1_reg;
    rcsb_pkg::pow_t  pf2_reg, pl2_reg;

    assign adv      = !(v2_reg && q_full);
    assign s_tready = adv && !cfg.busy && !cfg_we;
    assign acc      = s_tvalid && s_tready;
    assign push     = v2_reg && !q_full;

    always_comb
    begin
        v0_next = v0_reg;
        v1_next = v1_reg;
        v2_next = v2_reg;
        if (adv)
        begin
            v0_next = acc;
            v1_next = v0_reg;
            v2_next = v1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x0_reg   <= s_tdata;
            d0_reg   <= s_tuser;
            uf0_reg  <= rcsb_pkg::pos_diff(s_tdata, cfg.first);
            ul0_reg  <= rcsb_pkg::pos_diff(s_tdata, cfg.last);

            x1_reg   <= x0_reg;
            d1_reg   <= d0_reg;
            uf1_reg  <= uf0_reg;
            ul1_reg  <= ul0_reg;
            sqf1_reg <= uf0_reg * uf0_reg;
            sql1_reg <= ul0_reg * ul0_reg;

            x2_reg   <= x1_reg;
            d2_reg   <= d1_reg;
            pf2_reg  <= rcsb_pkg::pow_fin(sqf1_reg, uf1_reg, d1_reg);
            pl2_reg  <= rcsb_pkg::pow_fin(sql1_reg, ul1_reg, d1_reg);
        end
    end

    assign push_data.x     = x2_reg;
    assign push_data.deriv = d2_reg;
    assign push_data.pf    = pf2_reg;
    assign push_data.pl    = pl2_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rcsb_queue.sv =====
`default_nettype none

module rcsb_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire rcsb_pkg::smp_t  push_data,
    input  wire logic            pop,
    output logic                 full,
    output logic                 empty,
    output rcsb_pkg::smp_t       head
);

    rcsb_pkg::smp_t                mem_reg [rcsb_pkg::QDEPTH];
    logic [rcsb_pkg::QPTR_W-1:0]   wr_reg, wr_next, rd_reg, rd_next;
    logic [rcsb_pkg::QCNT_W-1:0]   cnt_reg, cnt_next;

    assign full  = (cnt_reg == rcsb_pkg::QCNT_W'(rcsb_pkg::QDEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? wr_reg + rcsb_pkg::QPTR_W'(1) : wr_reg;
        rd_next  = pop ? rd_reg + rcsb_pkg::QPTR_W'(1) : rd_reg;
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + rcsb_pkg::QCNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - rcsb_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ===== rtl/core/rcsb_back.sv =====
`default_nettype none

module rcsb_back (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire rcsb_pkg::cfg_view_t              cfg,
    input  wire logic                             q_empty,
    input  wire rcsb_pkg::smp_t                   q_head,
    output logic                                  pop,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [rcsb_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic                                  m_tlast,
    output logic                                  m_tuser
);

    logic [rcsb_pkg::COL_W-1:0]     col_reg, col_next;
    logic                           vb0_reg, vb1_reg, vb2_reg, vo_reg;
    logic                           vb0_next, vb1_next, vb2_next, vo_next;
    logic                           adv, issue, last_col;
    logic [rcsb_pkg::IDX_W-1:0]     kidx;
    logic [rcsb_pkg::COL_W-1:0]     lsub;
    logic [rcsb_pkg::LAM_IDX_W-1:0] lidx;
    rcsb_pkg::lam_t                 lam_sel;

    logic [rcsb_pkg::COL_W-1:0] c0_reg, c1_reg, c2_reg, co_reg;
    logic                       l0_reg, l1_reg, l2_reg, lo_reg;
    logic                       dv0_reg, dv1_reg, dv2_reg;
    rcsb_pkg::knot_t            x0_reg, x1_reg, x2_reg;
    rcsb_pkg::pow_t             pf0_reg, pl0_reg;
    rcsb_pkg::mag_t             uj0_reg, uj1_reg;
    rcsb_pkg::lam_t             lam0_reg;
    rcsb_pkg::sq_t              sq1_reg;
    rcsb_pkg::pow_t             wf1_reg, wl1_reg, p2_reg;
    logic [rcsb_pkg::POW_W:0]   ws2_reg;
    rcsb_pkg::val_t             vo_val_reg, val;

    assign adv      = !vo_reg || m_tready;
    assign issue    = adv && !q_empty;
    assign last_col = (col_reg == rcsb_pkg::COL_W'(cfg.n - rcsb_pkg::CNT_W'(1)));
    assign pop      = issue && last_col;

    assign kidx    = (col_reg == rcsb_pkg::COL_CONST) ? '0 : col_reg - rcsb_pkg::COL_W'(1);
    assign lsub    = col_reg - rcsb_pkg::COL_SPLINE;
    assign lidx    = lsub[rcsb_pkg::LAM_IDX_W-1:0];
    assign lam_sel = (col_reg >= rcsb_pkg::COL_SPLINE) ? cfg.lam[lidx] : '0;

    always_comb
    begin
        col_next = col_reg;
        vb0_next = vb0_reg;
        vb1_next = vb1_reg;
        vb2_next = vb2_reg;
        vo_next  = vo_reg;
        if (issue)
            col_next = last_col ? '0 : col_reg + rcsb_pkg::COL_W'(1);
        if (adv)
        begin
            vb0_next = issue;
            vb1_next = vb0_reg;
            vb2_next = vb1_reg;
            vo_next  = vb2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            vb0_reg <= 1'b0;
            vb1_reg <= 1'b0;
            vb2_reg <= 1'b0;
            vo_reg  <= 1'b0;
        end
        else
        begin
            col_reg <= col_next;
            vb0_reg <= vb0_next;
            vb1_reg <= vb1_next;
            vb2_reg <= vb2_next;
            vo_reg  <= vo_next;
        end
    end

    always_comb
    begin
        case (c2_reg)
            rcsb_pkg::COL_CONST:
                val = dv2_reg ? '0 : rcsb_pkg::VAL_ONE;
            rcsb_pkg::COL_LINEAR:
                val = dv2_reg ? rcsb_pkg::VAL_ONE
                              : {{(rcsb_pkg::VAL_W-rcsb_pkg::X_W){x2_reg[rcsb_pkg::X_W-1]}},
                                 x2_reg};
            default:
                val = {{(rcsb_pkg::VAL_W-rcsb_pkg::POW_W){1'b0}}, p2_reg}
                    - {{(rcsb_pkg::VAL_W-rcsb_pkg::POW_W-1){1'b0}}, ws2_reg};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c0_reg     <= col_reg;
            l0_reg     <= last_col;
            dv0_reg    <= q_head.deriv;
            x0_reg     <= q_head.x;
            pf0_reg    <= q_head.pf;
            pl0_reg    <= q_head.pl;
            uj0_reg    <= rcsb_pkg::pos_diff(q_head.x, cfg.knot[kidx]);
            lam0_reg   <= lam_sel;

            c1_reg     <= c0_reg;
            l1_reg     <= l0_reg;
            dv1_reg    <= dv0_reg;
            x1_reg     <= x0_reg;
            uj1_reg    <= uj0_reg;
            sq1_reg    <= uj0_reg * uj0_reg;
            wf1_reg    <= rcsb_pkg::weight(pf0_reg, lam0_reg);
            wl1_reg    <= rcsb_pkg::weight(pl0_reg, rcsb_pkg::LAM_ONE - lam0_reg);

            c2_reg     <= c1_reg;
            l2_reg     <= l1_reg;
            dv2_reg    <= dv1_reg;
            x2_reg     <= x1_reg;
            p2_reg     <= rcsb_pkg::pow_fin(sq1_reg, uj1_reg, dv1_reg);
            ws2_reg    <= {1'b0, wf1_reg} + {1'b0, wl1_reg};

            co_reg     <= c2_reg;
            lo_reg     <= l2_reg;
            vo_val_reg <= val;
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = {{(rcsb_pkg::OUT_DATA_W-rcsb_pkg::VAL_W-rcsb_pkg::COL_W){1'b0}},
                       vo_val_reg, co_reg};
    assign m_tlast  = lo_reg;
    assign m_tuser  = cfg.degen;

endmodule

`default_nettype wire

// ===== rtl/core/restricted_cubic_spline_basis_core.sv =====
// Restricted natural cubic spline basis. Each accepted word (sample x and a
// value/derivative select) yields one result word per basis column, columns 0
// to n-1 with n the knot count clamped to 2..6, one column per cycle while the
// output is not stalled and the queue holds a sample, so samples follow back to
// back; the column issue counter of the back end steps through the columns. The
// path runs through three front stages computing the boundary powers, a
// four-entry queue and four back-end stages. Lambdas are precomputed by a
// restoring divider: after any configuration write the input is held off until
// the lambdas of all four interior knots are computed.
`default_nettype none

module restricted_cubic_spline_basis_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [rcsb_pkg::IN_DATA_W-1:0]      s_tdata,   // sample_x
    input  wire logic                                s_tuser,   // mode
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [rcsb_pkg::OUT_DATA_W-1:0]          m_tdata,   // column, basis_value
    output logic                                     m_tlast,
    output logic                                     m_tuser,   // degenerate
    input  wire logic                                cfg_we,
    input  wire logic [rcsb_pkg::IDX_W-1:0]          cfg_index,
    input  wire logic [rcsb_pkg::X_W-1:0]            cfg_data
);

    rcsb_pkg::cfg_view_t cfg;
    rcsb_pkg::smp_t      push_data, q_head;
    logic                push, pop, q_full, q_empty;

    rcsb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rcsb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg       (cfg),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    rcsb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    rcsb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

// ===== rtl/core/rcsb_checker.sv =====
`default_nettype none

module rcsb_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tready,
    input  wire logic                                m_tvalid,
    input  wire logic                                m_tready,
    input  wire logic [rcsb_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  wire logic                                m_tlast,
    input  wire logic                                m_tuser,
    input  wire logic                                cfg_we
);

    logic                          out_acc;
    logic [rcsb_pkg::COL_W-1:0]    col;
    rcsb_pkg::val_t                value;
    logic [rcsb_pkg::COL_W-1:0]    exp_col_reg, exp_col_next;
    logic                          deg_reg, deg_next;

    assign out_acc = m_tvalid && m_tready;
    assign col     = m_tdata[rcsb_pkg::COL_W-1:0];
    assign value   = m_tdata[rcsb_pkg::VAL_W+rcsb_pkg::COL_W-1:rcsb_pkg::COL_W];

    always_comb
    begin
        exp_col_next = exp_col_reg;
        deg_next     = deg_reg;
        if (out_acc)
        begin
            exp_col_next = m_tlast ? '0 : col + rcsb_pkg::COL_W'(1);
            deg_next     = m_tuser;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_col_reg <= '0;
            deg_reg     <= 1'b0;
        end
        else
        begin
            exp_col_reg <= exp_col_next;
            deg_reg     <= deg_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    a_col_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> col == exp_col_reg)
        else $error("column out of order");

    a_degen_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && (exp_col_reg != rcsb_pkg::COL_CONST) |-> m_tuser == deg_reg)
        else $error("degenerate flag changed within a sample");

    a_cfg_block: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !s_tready)
        else $error("input taken during lambda update");

    a_const_col: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && (col == rcsb_pkg::COL_CONST) |-> (value == '0) || (value == rcsb_pkg::VAL_ONE))
        else $error("bad constant column value");

endmodule

bind restricted_cubic_spline_basis_core rcsb_checker u_rcsb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we)
);

`default_nettype wire
